// ===== sv/imm_pkg.sv =====
// Shared types, constants and a helper function for the integer matrix multiplier.
package imm_pkg;

   localparam int DIM_W = 4;
   localparam int IDX_W = 3;
   localparam int SIZE_W = 2 * DIM_W;
   localparam int PROD_W = 35;
   localparam int CSR_IDX_W = 2;

   localparam int MAX_DIM_DEFAULT = 8;
   localparam int ELEMENT_WIDTH_DEFAULT = 16;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_B = 2'd2;

   typedef enum logic [1:0] {
      S_LOAD = 2'b01,
      S_RUN  = 2'b10
   } imm_state_type;

   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] inner;
      logic [DIM_W-1:0] cols;
   } imm_dims_type;

   typedef struct packed {
      logic a_en;
      logic b_en;
   } imm_write_type;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      logic             run_end;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } imm_issue_type;

   // A zero dimension acts as one, and anything above the maximum acts as the maximum.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d,
                                                input logic [DIM_W-1:0] dmax);
      logic [DIM_W-1:0] r;
      r = d;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (d > dmax) begin
         r = dmax;
      end
      return r;
   endfunction

endpackage

// ===== sv/imm_sequencer.sv =====
// Load counters and the row, column and inner-index sequencer of the multiplier.
module imm_sequencer
   import imm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                operand_select,
   input  imm_dims_type        dims,
   output logic                busy,
   output imm_write_type       wr,
   output logic [((MAX_DIM*MAX_DIM) > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
   output logic [((MAX_DIM*MAX_DIM) > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_a_addr,
   output logic [((MAX_DIM*MAX_DIM) > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_b_addr,
   output imm_issue_type       issue
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [DIM_W-1:0] MAXD = DIM_W'(MAX_DIM);

   imm_state_type    state_ff, state_in;
   logic [CW-1:0]    a_cnt_ff, a_cnt_in;
   logic [CW-1:0]    b_cnt_ff, b_cnt_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [AW-1:0]    a_base_ff, a_base_in;
   logic [AW-1:0]    a_addr_ff, a_addr_in;
   logic [AW-1:0]    b_addr_ff, b_addr_in;

   logic [DIM_W-1:0]  dim_r, dim_n, dim_c;
   logic [SIZE_W-1:0] size_a, size_b;
   logic              k_last, j_last, i_last;

   assign dim_r = eff_dim(dims.rows, MAXD);
   assign dim_n = eff_dim(dims.inner, MAXD);
   assign dim_c = eff_dim(dims.cols, MAXD);
   assign size_a = SIZE_W'(dim_r) * SIZE_W'(dim_n);
   assign size_b = SIZE_W'(dim_n) * SIZE_W'(dim_c);

   assign k_last = (DIM_W'(k_ff) == dim_n - DIM_W'(1));
   assign j_last = (DIM_W'(j_ff) == dim_c - DIM_W'(1));
   assign i_last = (DIM_W'(i_ff) == dim_r - DIM_W'(1));

   assign busy = (state_ff == S_RUN);
   assign wr_addr = operand_select ? b_cnt_ff[AW-1:0] : a_cnt_ff[AW-1:0];
   assign rd_a_addr = a_addr_ff;
   assign rd_b_addr = b_addr_ff;

   always_comb begin
      state_in = state_ff;
      a_cnt_in = a_cnt_ff;
      b_cnt_in = b_cnt_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      a_base_in = a_base_ff;
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      wr = '0;
      issue = '0;
      case (state_ff)
         S_LOAD: begin
            if (load) begin
               if (!operand_select) begin
                  if (SIZE_W'(a_cnt_ff) < size_a) begin
                     wr.a_en = 1'b1;
                     a_cnt_in = a_cnt_ff + CW'(1);
                  end
               end else begin
                  if (SIZE_W'(b_cnt_ff) < size_b) begin
                     wr.b_en = 1'b1;
                     b_cnt_in = b_cnt_ff + CW'(1);
                  end
               end
               if (SIZE_W'(a_cnt_in) >= size_a && SIZE_W'(b_cnt_in) >= size_b) begin
                  a_cnt_in = '0;
                  b_cnt_in = '0;
                  i_in = '0;
                  j_in = '0;
                  k_in = '0;
                  a_base_in = '0;
                  a_addr_in = '0;
                  b_addr_in = '0;
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            issue.valid = 1'b1;
            issue.first = (k_ff == '0);
            issue.last = k_last;
            issue.run_end = k_last && j_last && i_last;
            issue.row = i_ff;
            issue.col = j_ff;
            if (!k_last) begin
               k_in = k_ff + IDX_W'(1);
               a_addr_in = a_addr_ff + AW'(1);
               b_addr_in = b_addr_ff + AW'(dim_c);
            end else begin
               k_in = '0;
               if (!j_last) begin
                  j_in = j_ff + IDX_W'(1);
                  a_addr_in = a_base_ff;
                  b_addr_in = AW'(j_ff) + AW'(1);
               end else begin
                  j_in = '0;
                  b_addr_in = '0;
                  if (!i_last) begin
                     i_in = i_ff + IDX_W'(1);
                     a_base_in = a_base_ff + AW'(dim_n);
                     a_addr_in = a_base_ff + AW'(dim_n);
                  end else begin
                     state_in = S_LOAD;
                  end
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         a_cnt_ff <= '0;
         b_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         a_cnt_ff <= a_cnt_in;
         b_cnt_ff <= b_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      a_base_ff <= a_base_in;
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
   end

endmodule

// ===== sv/imm_mac_unit.sv =====
// Matrix stores and the shared multiply-accumulate pipeline of the multiplier.
module imm_mac_unit
   import imm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  imm_write_type            wr,
   input  logic [((MAX_DIM*MAX_DIM) > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
   input  logic [ELEMENT_WIDTH-1:0] wr_data,
   input  logic [((MAX_DIM*MAX_DIM) > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_a_addr,
   input  logic [((MAX_DIM*MAX_DIM) > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_b_addr,
   input  imm_issue_type            issue,
   output logic                     rsp_strobe,
   output logic [PROD_W-1:0]        rsp_product_value,
   output logic [IDX_W-1:0]         rsp_out_row,
   output logic [IDX_W-1:0]         rsp_out_col,
   output logic                     rsp_last_of_run
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int MW = 2 * ELEMENT_WIDTH;

   logic [ELEMENT_WIDTH-1:0] a_mem [DEPTH];
   logic [ELEMENT_WIDTH-1:0] b_mem [DEPTH];

   logic signed [ELEMENT_WIDTH-1:0] a_rd_ff, b_rd_ff;
   logic signed [MW-1:0]            prod_ff, prod_in;
   logic [PROD_W-1:0]               prod_ext;
   logic [PROD_W-1:0]               acc_ff, acc_in;
   imm_issue_type                   s1_ff, s2_ff;
   logic                            strobe_ff, last_ff;
   logic [PROD_W-1:0]               value_ff;
   logic [IDX_W-1:0]                row_ff, col_ff;

   assign prod_in = a_rd_ff * b_rd_ff;

   if (MW >= PROD_W) begin : g_trunc
      assign prod_ext = prod_ff[PROD_W-1:0];
   end else begin : g_sext
      assign prod_ext = {{(PROD_W - MW){prod_ff[MW-1]}}, prod_ff};
   end

   assign acc_in = s2_ff.first ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      if (wr.a_en) begin
         a_mem[wr_addr] <= wr_data;
      end
      if (wr.b_en) begin
         b_mem[wr_addr] <= wr_data;
      end
      a_rd_ff <= a_mem[rd_a_addr];
      b_rd_ff <= b_mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         strobe_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         s1_ff <= issue;
         s2_ff <= s1_ff;
         strobe_ff <= s2_ff.valid && s2_ff.last;
         last_ff <= s2_ff.valid && s2_ff.last && s2_ff.run_end;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (s2_ff.valid) begin
         acc_ff <= acc_in;
      end
      value_ff <= acc_in;
      row_ff <= s2_ff.row;
      col_ff <= s2_ff.col;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_product_value = value_ff;
   assign rsp_out_row = row_ff;
   assign rsp_out_col = col_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ===== sv/integer_matrix_multiply.sv =====
// Top level of the integer matrix multiplier: dimension registers, sequencer and MAC unit.
//
// Channel   Handshake               Payload
// request   start, busy             req_operand_select, req_element_value
// response  rsp_strobe              rsp_product_value, rsp_out_row, rsp_out_col,
//                                   rsp_last_of_run
// csr       csr_valid, csr_ready    csr_index, csr_data
//
// A request that loads an element writes it into its matrix store. The request that completes both
// matrices starts a run that issues all rows * cols * inner product terms to the single
// multiplier, during which busy is high; each product element leaves through the s1, s2
// and output registers after its last term is issued. Reset is synchronous and restores all
// dimensions to eight with both load counts empty. The receiver cannot stall.
module integer_matrix_multiply
   import imm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_operand_select,
   input  logic [ELEMENT_WIDTH-1:0] req_element_value,
   output logic                     rsp_strobe,
   output logic [PROD_W-1:0]        rsp_product_value,
   output logic [IDX_W-1:0]         rsp_out_row,
   output logic [IDX_W-1:0]         rsp_out_col,
   output logic                     rsp_last_of_run,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DIM_W-1:0]         csr_data
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   imm_dims_type  dims_ff;
   imm_write_type wr;
   imm_issue_type issue;
   logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;
   logic          load;

   assign csr_ready = 1'b1;
   assign load = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.rows <= DIM_RESET;
         dims_ff.inner <= DIM_RESET;
         dims_ff.cols <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ROWS_A: dims_ff.rows <= csr_data;
            REG_INNER_DIM: dims_ff.inner <= csr_data;
            REG_COLS_B: dims_ff.cols <= csr_data;
            default: ;
         endcase
      end
   end

   imm_sequencer #(
      .MAX_DIM(MAX_DIM)
   ) u_sequencer (
      .clock(clock),
      .reset(reset),
      .load(load),
      .operand_select(req_operand_select),
      .dims(dims_ff),
      .busy(busy),
      .wr(wr),
      .wr_addr(wr_addr),
      .rd_a_addr(rd_a_addr),
      .rd_b_addr(rd_b_addr),
      .issue(issue)
   );

   imm_mac_unit #(
      .MAX_DIM(MAX_DIM),
      .ELEMENT_WIDTH(ELEMENT_WIDTH)
   ) u_mac_unit (
      .clock(clock),
      .reset(reset),
      .wr(wr),
      .wr_addr(wr_addr),
      .wr_data(req_element_value),
      .rd_a_addr(rd_a_addr),
      .rd_b_addr(rd_b_addr),
      .issue(issue),
      .rsp_strobe(rsp_strobe),
      .rsp_product_value(rsp_product_value),
      .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col),
      .rsp_last_of_run(rsp_last_of_run)
   );

   // A run begins only on an accepted request.
   a_run_starts_on_request: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("Run started without an accepted request.");

   // The final product term ends the run.
   a_run_ends_after_final: assert property (@(posedge clock) disable iff (reset)
      issue.valid && issue.run_end |=> !busy)
      else $error("Sequencer stayed busy after the final product term.");

   // Every response follows the last term of its sum through the pipeline.
   a_response_timing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(issue.valid && issue.last, 3))
      else $error("Response without a matching completed sum.");

   // The end-of-run mark only appears on a response.
   a_last_needs_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_run |-> rsp_strobe)
      else $error("End-of-run mark without a response.");

endmodule
